FILE: hw/rtl/blake2b_128_hash_core_assert.svh
// Assertion macros for the BLAKE2b-128 hash core
`ifndef BLAKE2B_128_HASH_CORE_ASSERT_SVH
`define BLAKE2B_128_HASH_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define B2B_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define B2B_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define B2B_ASSERT_IMP(label, clk, rst_n, a, c)
`define B2B_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

FILE: hw/rtl/b2b_pkg.sv
// ----------------------------------------------------------------------------
// b2b_pkg
// Shared types and constants of the BLAKE2b-128 hash core.
// ----------------------------------------------------------------------------
`default_nettype none
package b2b_pkg;
    localparam logic [63:0] PARAM_WORD = 64'h0000_0000_0101_0010;

    typedef logic [63:0] word_t;

    // one beat from the front part to the compression part
    typedef struct packed {
        logic       store;  // write word into the block
        logic       flush;  // compress waiting full block as non-final first
        logic       fin;    // compress final block and emit
        logic [3:0] nb;     // bytes carried by the word
        word_t      word;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE, ST_LOAD, ST_ROUND, ST_DONE
    } eng_state_t;

    function automatic word_t iv(input logic [2:0] i);
        word_t r;
        case (i)
            3'd0: r = 64'h6a09e667f3bcc908;
            3'd1: r = 64'hbb67ae8584caa73b;
            3'd2: r = 64'h3c6ef372fe94f82b;
            3'd3: r = 64'ha54ff53a5f1d36f1;
            3'd4: r = 64'h510e527fade682d1;
            3'd5: r = 64'h9b05688c2b3e6c1f;
            3'd6: r = 64'h1f83d9abfb41bd6b;
            default: r = 64'h5be0cd19137e2179;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] k);
        logic [63:0] row;
        case (r)
            4'd0: row = 64'h0123456789abcdef;
            4'd1: row = 64'hea489fd61c02b753;
            4'd2: row = 64'hb8c052fdae367194;
            4'd3: row = 64'h7931dcbe265a40f8;
            4'd4: row = 64'h905724afe1bc683d;
            4'd5: row = 64'h2c6a0b834d75fe19;
            4'd6: row = 64'hc51fed4a0763928b;
            4'd7: row = 64'hdb7ec13950f4862a;
            4'd8: row = 64'h6fe9b308c2d714a5;
            default: row = 64'ha2847615fb9e3cd0;
        endcase
        return row[(4'd15 - k) * 4 +: 4];
    endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/b2b_front.sv
// ----------------------------------------------------------------------------
// b2b_front
// Accept message words, mask the last one and classify each into a command.
// ----------------------------------------------------------------------------
`default_nettype none
module b2b_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire logic [63:0]    message_word,
    input  wire logic [3:0]     valid_bytes,
    input  wire logic           last_word,
    output b2b_pkg::cmd_t       cmd,
    output logic                cmd_valid,
    input  wire logic           cmd_ready
);
    logic [4:0] cnt_reg, cnt_next;
    logic [3:0] nb;
    logic [63:0] w;
    logic acc;

    assign full = !cmd_ready;
    assign acc  = push && cmd_ready;
    assign cmd_valid = acc;

    always_comb
    begin
        nb = (!last_word || valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
        w  = message_word;
        for (int i = 0; i < 8; i++)
            if (4'(i) >= nb) w[i*8 +: 8] = 8'h00;
        cmd.word  = w;
        cmd.nb    = nb;
        cmd.flush = (cnt_reg == 5'd16) && (nb != 4'd0);
        cmd.store = (nb != 4'd0);
        cmd.fin   = last_word;
        cnt_next  = cnt_reg;
        if (acc)
        begin
            if (last_word) cnt_next = 5'd0;
            else if (cnt_reg == 5'd16) cnt_next = 5'd1;
            else cnt_next = cnt_reg + 5'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) cnt_reg <= 5'd0;
        else        cnt_reg <= cnt_next;
    end
endmodule
`default_nettype wire

FILE: hw/rtl/b2b_queue.sv
// ----------------------------------------------------------------------------
// b2b_queue
// Two-entry command queue between the front part and the compression part.
// ----------------------------------------------------------------------------
`default_nettype none
`include "blake2b_128_hash_core_assert.svh"
module b2b_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire b2b_pkg::cmd_t  in_cmd,
    input  wire logic           in_valid,
    output logic                in_ready,
    output b2b_pkg::cmd_t       out_cmd,
    output logic                out_valid,
    input  wire logic           out_ready
);
    b2b_pkg::cmd_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic wr, rd;

    assign in_ready  = cnt_reg != 2'd2;
    assign out_valid = cnt_reg != 2'd0;
    assign out_cmd   = mem_reg[rp_reg];
    assign wr = in_valid && in_ready;
    assign rd = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= in_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    `B2B_ASSERT_IMP(a_q_bound, clk, rst_n, 1'b1, cnt_reg != 2'd3)
    `B2B_ASSERT_NXT(a_q_ptr, clk, rst_n, wr && !rd && cnt_reg == 2'd1, cnt_reg == 2'd2)
    `B2B_ASSERT_IMP(a_q_eq, clk, rst_n, cnt_reg == 2'd0 || cnt_reg == 2'd2,
        wp_reg == rp_reg)
endmodule
`default_nettype wire

FILE: hw/rtl/b2b_engine.sv
// ----------------------------------------------------------------------------
// b2b_engine
// Block buffer, counter and one G unit doing half a mix a cycle, 192 steps a block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "blake2b_128_hash_core_assert.svh"
module b2b_engine (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire b2b_pkg::cmd_t  cmd,
    input  wire logic           cmd_valid,
    output logic                cmd_ready,
    output logic                empty,
    input  wire logic           pop,
    output logic [63:0]         digest_low,
    output logic [63:0]         digest_high
);
    b2b_pkg::eng_state_t st_reg, st_next;
    logic [63:0] h_reg [8];
    logic [63:0] m_reg [16];
    logic [63:0] v_reg [16];
    logic [63:0] cl_reg, ch_reg;
    logic [3:0]  wi_reg;
    logic [3:0]  rnd_reg;
    logic [2:0]  g_reg;
    logic        ph_reg;    // second half of the mix
    logic        fin_reg;   // current compression is the final one
    logic        more_reg;  // flushed word also ends the message
    logic [63:0] pw_reg;
    logic [3:0]  pnb_reg;
    logic        out_v_reg, out_v_next;
    logic [63:0] dl_reg, dh_reg;

    logic [3:0] ia, ib, ic, id, rr;
    logic [63:0] ms, a_n, dx, d_n, c_n, bx, b_n;
    logic take, last_step, emit;

    assign empty = !out_v_reg;
    assign digest_low = dl_reg;
    assign digest_high = dh_reg;
    assign take = cmd_valid && cmd_ready;
    assign last_step = (rnd_reg == 4'd11) && (g_reg == 3'd7) && ph_reg;

    always_comb
    begin
        case (g_reg)
            3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
            3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
            3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
            3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
            3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
            3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
            3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
            default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
        endcase
        rr = (rnd_reg >= 4'd10) ? rnd_reg - 4'd10 : rnd_reg;
        ms = m_reg[b2b_pkg::sigma(rr, {g_reg, ph_reg})];
        a_n = v_reg[ia] + v_reg[ib] + ms;
        dx = v_reg[id] ^ a_n;
        d_n = ph_reg ? {dx[15:0], dx[63:16]} : {dx[31:0], dx[63:32]};
        c_n = v_reg[ic] + d_n;
        bx = v_reg[ib] ^ c_n;
        b_n = ph_reg ? {bx[62:0], bx[63]} : {bx[23:0], bx[63:24]};
    end

    always_comb
    begin
        st_next = st_reg;
        cmd_ready = 1'b0;
        emit = 1'b0;
        case (st_reg)
            b2b_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid && (cmd.flush || cmd.fin)) st_next = b2b_pkg::ST_LOAD;
            end
            b2b_pkg::ST_LOAD:
                st_next = b2b_pkg::ST_ROUND;
            b2b_pkg::ST_ROUND:
                if (last_step) st_next = b2b_pkg::ST_DONE;
            b2b_pkg::ST_DONE:
            begin
                if (!fin_reg)
                    st_next = more_reg ? b2b_pkg::ST_LOAD : b2b_pkg::ST_IDLE;
                else if (!out_v_reg || pop)
                begin
                    // hold the digest until the previous one has left
                    emit = 1'b1;
                    st_next = b2b_pkg::ST_IDLE;
                end
            end
            default: st_next = b2b_pkg::ST_IDLE;
        endcase
        out_v_next = emit ? 1'b1 : ((pop && out_v_reg) ? 1'b0 : out_v_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= b2b_pkg::ST_IDLE;
            out_v_reg <= 1'b0;
            fin_reg <= 1'b0;
            more_reg <= 1'b0;
            wi_reg <= 4'd0;
            rnd_reg <= 4'd0;
            g_reg <= 3'd0;
            ph_reg <= 1'b0;
            cl_reg <= '0; ch_reg <= '0;
            for (int i = 0; i < 8; i++)
                h_reg[i] <= b2b_pkg::iv(3'(i)) ^ ((i == 0) ? b2b_pkg::PARAM_WORD : 64'd0);
            for (int i = 0; i < 16; i++) m_reg[i] <= '0;
        end
        else
        begin
            st_reg <= st_next;
            out_v_reg <= out_v_next;
            case (st_reg)
                b2b_pkg::ST_IDLE:
                    if (take)
                    begin
                        fin_reg <= !cmd.flush;
                        more_reg <= cmd.flush && cmd.fin;
                        if (cmd.store && !cmd.flush)
                        begin
                            m_reg[wi_reg] <= cmd.word;
                            wi_reg <= wi_reg + 4'd1;
                            {ch_reg, cl_reg} <= {ch_reg, cl_reg} + 128'(cmd.nb);
                        end
                    end
                b2b_pkg::ST_LOAD:
                begin
                    rnd_reg <= 4'd0; g_reg <= 3'd0; ph_reg <= 1'b0;
                end
                b2b_pkg::ST_ROUND:
                begin
                    ph_reg <= !ph_reg;
                    if (ph_reg)
                    begin
                        g_reg <= g_reg + 3'd1;
                        if (g_reg == 3'd7) rnd_reg <= rnd_reg + 4'd1;
                    end
                end
                b2b_pkg::ST_DONE:
                    if (!fin_reg)
                    begin
                        for (int i = 0; i < 8; i++)
                            h_reg[i] <= h_reg[i] ^ v_reg[i] ^ v_reg[i+8];
                        for (int i = 1; i < 16; i++) m_reg[i] <= '0;
                        // place the word that forced the flush
                        m_reg[0] <= pw_reg;
                        wi_reg <= 4'd1;
                        {ch_reg, cl_reg} <= {ch_reg, cl_reg} + 128'(pnb_reg);
                        fin_reg <= 1'b1;
                        more_reg <= 1'b0;
                    end
                    else if (emit)
                    begin
                        for (int i = 0; i < 8; i++)
                            h_reg[i] <= b2b_pkg::iv(3'(i)) ^
                                ((i == 0) ? b2b_pkg::PARAM_WORD : 64'd0);
                        for (int i = 0; i < 16; i++) m_reg[i] <= '0;
                        wi_reg <= 4'd0;
                        cl_reg <= '0; ch_reg <= '0;
                    end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pw_reg <= cmd.word;
            pnb_reg <= cmd.nb;
        end
        if (st_reg == b2b_pkg::ST_LOAD)
        begin
            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
            for (int i = 0; i < 4; i++) v_reg[i+8] <= b2b_pkg::iv(3'(i));
            v_reg[12] <= b2b_pkg::iv(3'd4) ^ cl_reg;
            v_reg[13] <= b2b_pkg::iv(3'd5) ^ ch_reg;
            v_reg[14] <= fin_reg ? ~b2b_pkg::iv(3'd6) : b2b_pkg::iv(3'd6);
            v_reg[15] <= b2b_pkg::iv(3'd7);
        end
        if (st_reg == b2b_pkg::ST_ROUND)
        begin
            v_reg[ia] <= a_n; v_reg[ib] <= b_n;
            v_reg[ic] <= c_n; v_reg[id] <= d_n;
        end
        if (emit)
        begin
            dl_reg <= h_reg[0] ^ v_reg[0] ^ v_reg[8];
            dh_reg <= h_reg[1] ^ v_reg[1] ^ v_reg[9];
        end
    end

    `B2B_ASSERT_IMP(a_e_busy, clk, rst_n, st_reg != b2b_pkg::ST_IDLE, !cmd_ready)
    `B2B_ASSERT_NXT(a_e_done, clk, rst_n, emit, !empty)
    `B2B_ASSERT_NXT(a_e_hold, clk, rst_n, !empty && !pop, !empty && $stable(digest_low))
endmodule
`default_nettype wire

FILE: hw/rtl/blake2b_128_hash_core.sv
// A last word yields its digest after it passes through the queue, the load step, 192 half G
// steps and the finish step; when it also starts a new block, two compressions run before it.
// Other words are absorbed while the compression part is idle; it takes no word while busy.
// A full 16-word block is compressed when the word after it forces a flush.
// Reset (rst_n, async, low) restores the IV chain value, clears block, counter and queue.
// ----------------------------------------------------------------------------
// blake2b_128_hash_core
// Streaming unkeyed BLAKE2b with 16-byte digest.
// ----------------------------------------------------------------------------
`default_nettype none
module blake2b_128_hash_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [63:0] message_word,
    input  wire logic [3:0]  valid_bytes,
    input  wire logic        last_word,
    output logic             empty,
    input  wire logic        pop,
    output logic [63:0]      digest_low,
    output logic [63:0]      digest_high
);
    b2b_pkg::cmd_t f_cmd, q_cmd;
    logic f_valid, f_ready, q_valid, q_ready;

    b2b_front u_front (.clk, .rst_n, .push, .full, .message_word, .valid_bytes,
        .last_word, .cmd(f_cmd), .cmd_valid(f_valid), .cmd_ready(f_ready));
    b2b_queue u_queue (.clk, .rst_n, .in_cmd(f_cmd), .in_valid(f_valid),
        .in_ready(f_ready), .out_cmd(q_cmd), .out_valid(q_valid), .out_ready(q_ready));
    b2b_engine u_engine (.clk, .rst_n, .cmd(q_cmd), .cmd_valid(q_valid),
        .cmd_ready(q_ready), .empty, .pop, .digest_low, .digest_high);
endmodule
`default_nettype wire
